[hdl/lzss_ring_decompressor_assert.svh]
// assertion macros for the lzss ring decompressor
// expects clk_i and rst_ni in the scope of use
`ifndef LZSS_RING_DECOMPRESSOR_ASSERT_SVH
`define LZSS_RING_DECOMPRESSOR_ASSERT_SVH

// property holds in the same cycle
`define LZSD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LZSD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/lzsd_pkg.sv]
// shared types and constants of the lzss ring decompressor
// no dependencies
package lzsd_pkg;

  localparam int unsigned WindowSize = 4096;
  localparam int unsigned MaxMatch   = 18;
  localparam int unsigned WinAw      = $clog2(WindowSize);
  localparam int unsigned FillW      = WinAw + 1;
  localparam int unsigned LenW       = $clog2(MaxMatch + 1);

  localparam logic [WinAw-1:0] WpInit     = WinAw'(WindowSize - MaxMatch);
  localparam logic [FillW-1:0] FillFull   = FillW'(WindowSize);
  localparam logic [7:0]       SpaceByte  = 8'h20;
  localparam logic [LenW-1:0]  LenBias    = LenW'(3);
  localparam logic [3:0]       FlagsPerGrp = 4'd8;

  // control state codes
  localparam logic [1:0] StFlag  = 2'd0;
  localparam logic [1:0] StToken = 2'd1;
  localparam logic [1:0] StMatHi = 2'd2;
  localparam logic [1:0] StCopy  = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_word_t;

endpackage

[hdl/lzss_ring_decompressor.sv]
// lzss decompressor over a 4096-byte history ring held in one synchronous memory
// depends on lzsd_pkg and lzss_ring_decompressor_assert.svh

// Takes one compressed byte per input word and gives one decompressed byte per
// output word. The second byte of a match starts a copy of n = 3..18 bytes
// that leaves the ring one byte per cycle, while the output is not stalled,
// through the memory's single read port, whose read data is registered; no
// new input word is taken during the copy, and the next word is taken right
// after the last copied byte. The ring needs no clearing pass: a fill count of
// the bytes written since reset or stream end makes unwritten entries read as
// spaces, so the block is ready right after reset, and after a stream-end word
// once any copy that it ends and any output stall are done.
module lzss_ring_decompressor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lzsd_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lzsd_pkg::out_word_t out_word_o
);

`include "lzss_ring_decompressor_assert.svh"

  logic [7:0] mem [lzsd_pkg::WindowSize];
  logic [7:0] rd_q;

  logic [1:0]                      state_q, state_d;
  logic [7:0]                      flag_q, flag_d;
  logic [3:0]                      frem_q, frem_d;
  logic [7:0]                      held_q, held_d;
  logic [lzsd_pkg::WinAw-1:0]      wp_q, wp_d;
  logic [lzsd_pkg::FillW-1:0]      fill_q, fill_d;
  logic [lzsd_pkg::WinAw-1:0]      rd_addr_q, rd_addr_d;
  logic [lzsd_pkg::LenW-1:0]       rd_left_q, rd_left_d;
  logic [lzsd_pkg::LenW-1:0]       em_left_q, em_left_d;
  logic                            rdv_q, rdv_d;
  logic                            fwd_q, fwd_d;
  logic [7:0]                      fwd_byte_q, fwd_byte_d;
  logic                            hit_q, hit_d;
  logic                            end_pend_q, end_pend_d;
  lzsd_pkg::out_word_t             out_q, out_d;
  logic                            out_vld_q, out_vld_d;

  logic                       out_free, in_acc, lit, match_go;
  logic                       cp_emit, cp_last, rd_issue, we, ring_clr;
  logic [7:0]                 copy_byte, wdata;
  logic [lzsd_pkg::WinAw-1:0] rd_off;
  logic                       rd_hit;
  logic [3:0]                 frem_dec;

  assign out_free   = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q != lzsd_pkg::StCopy) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign lit        = in_acc && (state_q == lzsd_pkg::StToken) && flag_q[0];
  assign match_go   = in_acc && (state_q == lzsd_pkg::StMatHi);

  assign copy_byte = fwd_q ? fwd_byte_q : (hit_q ? rd_q : lzsd_pkg::SpaceByte);
  assign cp_emit   = (state_q == lzsd_pkg::StCopy) && rdv_q && out_free;
  assign cp_last   = cp_emit && (em_left_q == lzsd_pkg::LenW'(1));
  assign rd_issue  = (state_q == lzsd_pkg::StCopy) && (rd_left_q != '0) &&
                     (!rdv_q || cp_emit);

  assign we    = lit || cp_emit;
  assign wdata = lit ? in_word_i.in_byte : copy_byte;

  // entry holds a written byte only if it lies within the fill span from the start
  assign rd_off = rd_addr_q - lzsd_pkg::WpInit;
  assign rd_hit = {1'b0, rd_off} < fill_q;

  assign ring_clr = (in_acc && in_word_i.stream_end && !match_go) ||
                    (cp_last && end_pend_q);

  assign frem_dec = (frem_q != '0) ? frem_q - 4'd1 : frem_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wp_q] <= wdata;
    end
    if (rd_issue) begin
      rd_q <= mem[rd_addr_q];
    end
  end

  always_comb begin
    state_d    = state_q;
    flag_d     = flag_q;
    frem_d     = frem_q;
    held_d     = held_q;
    wp_d       = wp_q;
    fill_d     = fill_q;
    end_pend_d = end_pend_q;

    if (in_acc) begin
      unique case (state_q)
        lzsd_pkg::StToken: begin
          if (flag_q[0]) begin
            flag_d  = flag_q >> 1;
            frem_d  = frem_dec;
            state_d = (frem_dec == '0) ? lzsd_pkg::StFlag : lzsd_pkg::StToken;
          end else begin
            held_d  = in_word_i.in_byte;
            state_d = lzsd_pkg::StMatHi;
          end
        end
        lzsd_pkg::StMatHi: begin
          state_d    = lzsd_pkg::StCopy;
          end_pend_d = in_word_i.stream_end;
        end
        default: begin
          flag_d  = in_word_i.in_byte;
          frem_d  = lzsd_pkg::FlagsPerGrp;
          state_d = lzsd_pkg::StToken;
        end
      endcase
    end

    if (cp_last) begin
      flag_d     = flag_q >> 1;
      frem_d     = frem_dec;
      state_d    = (frem_dec == '0) ? lzsd_pkg::StFlag : lzsd_pkg::StToken;
      end_pend_d = 1'b0;
    end

    if (we) begin
      wp_d = wp_q + lzsd_pkg::WinAw'(1);
      if (fill_q != lzsd_pkg::FillFull) begin
        fill_d = fill_q + lzsd_pkg::FillW'(1);
      end
    end

    if (ring_clr) begin
      state_d    = lzsd_pkg::StFlag;
      flag_d     = '0;
      frem_d     = '0;
      held_d     = '0;
      wp_d       = lzsd_pkg::WpInit;
      fill_d     = '0;
      end_pend_d = 1'b0;
    end
  end

  always_comb begin
    rd_addr_d  = rd_addr_q;
    rd_left_d  = rd_left_q;
    em_left_d  = em_left_q;
    rdv_d      = rdv_q;
    fwd_d      = fwd_q;
    fwd_byte_d = fwd_byte_q;
    hit_d      = hit_q;

    if (match_go) begin
      rd_addr_d = {in_word_i.in_byte[7:4], held_q};
      rd_left_d = lzsd_pkg::LenW'(in_word_i.in_byte[3:0]) + lzsd_pkg::LenBias;
      em_left_d = lzsd_pkg::LenW'(in_word_i.in_byte[3:0]) + lzsd_pkg::LenBias;
    end

    if (cp_emit) begin
      em_left_d = em_left_q - lzsd_pkg::LenW'(1);
      rdv_d     = 1'b0;
    end

    if (rd_issue) begin
      rd_addr_d  = rd_addr_q + lzsd_pkg::WinAw'(1);
      rd_left_d  = rd_left_q - lzsd_pkg::LenW'(1);
      rdv_d      = 1'b1;
      // byte written this cycle at the read address bypasses the memory
      fwd_d      = cp_emit && (rd_addr_q == wp_q);
      fwd_byte_d = copy_byte;
      hit_d      = rd_hit;
    end
  end

  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q;
    if (lit) begin
      out_d.out_byte = in_word_i.in_byte;
      out_d.run_last = 1'b1;
      out_vld_d      = 1'b1;
    end else if (cp_emit) begin
      out_d.out_byte = copy_byte;
      out_d.run_last = cp_last;
      out_vld_d      = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lzsd_pkg::StFlag;
      flag_q     <= '0;
      frem_q     <= '0;
      held_q     <= '0;
      wp_q       <= lzsd_pkg::WpInit;
      fill_q     <= '0;
      end_pend_q <= 1'b0;
      rdv_q      <= 1'b0;
      rd_left_q  <= '0;
      em_left_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      flag_q     <= flag_d;
      frem_q     <= frem_d;
      held_q     <= held_d;
      wp_q       <= wp_d;
      fill_q     <= fill_d;
      end_pend_q <= end_pend_d;
      rdv_q      <= rdv_d;
      rd_left_q  <= rd_left_d;
      em_left_q  <= em_left_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q  <= rd_addr_d;
    fwd_q      <= fwd_d;
    fwd_byte_q <= fwd_byte_d;
    hit_q      <= hit_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  `LZSD_ASSERT(a_read_ahead, (state_q != lzsd_pkg::StCopy) || (em_left_q == rd_left_q + lzsd_pkg::LenW'(rdv_q)), "copy counters out of step")
  `LZSD_ASSERT(a_idle_no_read, (state_q == lzsd_pkg::StCopy) || !rdv_q, "read data pending outside a copy")
  `LZSD_ASSERT(a_fill_bound, fill_q <= lzsd_pkg::FillFull, "fill count beyond window")
  `LZSD_ASSERT(a_token_count, (state_q != lzsd_pkg::StToken) || (frem_q != '0), "token expected with no flags left")
  `LZSD_ASSERT_NEXT(a_copy_done, cp_last, (state_q != lzsd_pkg::StCopy) && out_valid_o && out_word_o.run_last, "copy did not end on its last byte")

endmodule
